FILE: src/uaf_pkg.sv
// Shared types, character codes and reciprocal constants for the uptime formatter.
`default_nettype none

package uaf_pkg;

  typedef struct packed {
    logic [7:0]  command_byte;
    logic [30:0] uptime_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
  } out_item_t;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_SEC = 2'd0;
  localparam mode_t MODE_MIN = 2'd1;
  localparam mode_t MODE_RAW = 2'd2;

  localparam logic [7:0] CMD_SECONDS = 8'h31;
  localparam logic [7:0] CMD_MINUTES = 8'h32;
  localparam logic [7:0] CMD_RAW     = 8'h33;
  localparam logic [7:0] CMD_QUIT    = 8'h71;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // count mod 1000000 = ((count >> 6) mod 15625) * 64 + count[5:0]
  localparam logic [24:0] WRAP_ODD   = 25'd15625;
  localparam logic [25:0] RECIP_WRAP = 26'd35184373;  // ceil(2^39 / 15625)
  localparam logic [20:0] RECIP_100  = 21'd1342178;   // ceil(2^27 / 100), x < 2^20
  localparam logic [13:0] RECIP_60   = 14'd8739;      // ceil(2^19 / 60),  x < 10000
  localparam logic [13:0] RECIP_100S = 14'd10486;     // ceil(2^20 / 100), x < 10000
  localparam logic [7:0]  RECIP_10   = 8'd205;        // ceil(2^11 / 10),  x < 128

  // Two ASCII digits {tens, units} of a value below one hundred
  function automatic logic [15:0] two_digits(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  u;
    p = 15'(v) * 15'(RECIP_10);
    t = p[14:11];
    u = v - (7'(t) << 3) - (7'(t) << 1);
    return {8'(CH_ZERO + {4'b0, t}), 8'(CH_ZERO + {4'b0, u[3:0]})};
  endfunction

endpackage

`default_nettype wire

FILE: src/uptime_ascii_formatter.sv
// Uptime formatter: command in, run of ASCII characters out.
//
// Input channel in_valid/in_ready/in_data carries a command byte and the
// uptime count in hundredths of a second. Commands '1', '2' and '3' each
// produce a run of characters on out_valid/out_ready/out_data, one
// character per transfer, the last one flagged by last_char. Command 'q'
// halts the block: every later command is taken and dropped until reset.
// Other bytes are taken and produce nothing.
// A command passes stage registers 1 to 6, the character shift register
// and the output register. Throughput: one character per cycle on the
// single output port while out_ready is high; runs are 8 characters
// ('1', '2') or 7 ('3'); dropped commands fill no stage. The arithmetic
// (modulo reduction and the divisions by 100 and 60) runs in a six-stage
// pipeline that holds up to six commands while a run is being sent.
// Reset (synchronous, rst_n low) clears the halt and empties the pipeline
// and the output register.
// When the receiver stalls, the output register holds its character, the
// pipeline fills, and in_ready drops once every stage is occupied.
`default_nettype none

module uptime_ascii_formatter
  import uaf_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire        out_ready,
  output out_item_t  out_data
);

  logic in_fire;
  logic keep;
  mode_t in_mode;
  logic halted_r, halted_nxt;

  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // stage 1: raw count
  logic        s1_v_r;
  mode_t       s1_mode_r;
  logic [30:0] s1_count_r;
  logic [50:0] p1;

  // stage 2: quotient of the wrap reduction
  logic        s2_v_r;
  mode_t       s2_mode_r;
  logic [11:0] s2_q_r;
  logic [24:0] s2_c6_r;
  logic [5:0]  s2_low_r;
  logic [24:0] qm;
  logic [24:0] rem;

  // stage 3: reduced count
  logic        s3_v_r;
  mode_t       s3_mode_r;
  logic [19:0] s3_red_r;
  logic [40:0] p3;

  // stage 4: whole seconds
  logic        s4_v_r;
  mode_t       s4_mode_r;
  logic [19:0] s4_red_r;
  logic [13:0] s4_secs_r;
  logic [19:0] cs_full;
  logic [26:0] p_min;
  logic [26:0] p_hs;

  // stage 5: minutes, hundredths, top two digits of seconds
  logic        s5_v_r;
  mode_t       s5_mode_r;
  logic [6:0]  s5_cs_r;
  logic [13:0] s5_secs_r;
  logic [7:0]  s5_mins_r;
  logic [6:0]  s5_hs_r;
  logic [13:0] sub_full;
  logic [13:0] ls_full;
  logic [6:0]  mm;

  // stage 6: values below one hundred, ready for digit split
  logic        s6_v_r;
  mode_t       s6_mode_r;
  logic [6:0]  s6_hs_r;
  logic [6:0]  s6_ls_r;
  logic [6:0]  s6_cs_r;
  logic [6:0]  s6_mm_r;
  logic [5:0]  s6_sub_r;
  logic [15:0] hs_d, ls_d, cs_d, mm_d, sub_d;
  logic [7:0][7:0] load_chars;
  logic [3:0]  load_cnt;

  // character shift register and output register
  logic [7:0][7:0] chr_r;
  logic [3:0]  chr_cnt_r;
  logic        emit;
  logic        chr_ready;
  logic        load;
  logic        out_v_r;
  out_item_t   out_data_r;

  // ---------------- input decode ----------------
  assign in_fire = in_valid && in_ready;

  always_comb begin
    in_mode = MODE_SEC;
    keep    = 1'b0;
    case (in_data.command_byte)
      CMD_SECONDS: begin
        in_mode = MODE_SEC;
        keep    = 1'b1;
      end
      CMD_MINUTES: begin
        in_mode = MODE_MIN;
        keep    = 1'b1;
      end
      CMD_RAW: begin
        in_mode = MODE_RAW;
        keep    = 1'b1;
      end
      default: begin
        in_mode = MODE_SEC;
        keep    = 1'b0;
      end
    endcase
    if (halted_r) begin
      keep = 1'b0;
    end
  end

  assign halted_nxt = halted_r || (in_fire && (in_data.command_byte == CMD_QUIT));

  // ---------------- ready chain ----------------
  assign emit      = (chr_cnt_r != 4'd0) && (!out_v_r || out_ready);
  assign chr_ready = (chr_cnt_r == 4'd0) || ((chr_cnt_r == 4'd1) && emit);
  assign load      = s6_v_r && chr_ready;

  assign rdy6 = !s6_v_r || chr_ready;
  assign rdy5 = !s5_v_r || rdy6;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  // ---------------- datapath ----------------
  assign p1 = 51'(s1_count_r[30:6]) * 51'(RECIP_WRAP);

  assign qm  = 25'(s2_q_r) * WRAP_ODD;
  assign rem = s2_c6_r - qm;

  assign p3 = 41'(s3_red_r) * 41'(RECIP_100);

  assign cs_full = s4_red_r - (20'(s4_secs_r) * 20'd100);
  assign p_min   = 27'(s4_secs_r) * 27'(RECIP_60);
  assign p_hs    = 27'(s4_secs_r) * 27'(RECIP_100S);

  assign sub_full = s5_secs_r - (14'(s5_mins_r) * 14'd60);
  assign ls_full  = s5_secs_r - (14'(s5_hs_r) * 14'd100);
  // only the last two digits of the minutes are shown
  assign mm = (s5_mins_r >= 8'd100) ? 7'(s5_mins_r - 8'd100) : s5_mins_r[6:0];

  assign hs_d  = two_digits(s6_hs_r);
  assign ls_d  = two_digits(s6_ls_r);
  assign cs_d  = two_digits(s6_cs_r);
  assign mm_d  = two_digits(s6_mm_r);
  assign sub_d = two_digits({1'b0, s6_sub_r});

  always_comb begin
    load_chars = '0;
    load_cnt   = 4'd0;
    case (s6_mode_r)
      MODE_SEC: begin
        load_chars[0] = hs_d[15:8];
        load_chars[1] = hs_d[7:0];
        load_chars[2] = ls_d[15:8];
        load_chars[3] = ls_d[7:0];
        load_chars[4] = CH_DOT;
        load_chars[5] = cs_d[15:8];
        load_chars[6] = cs_d[7:0];
        load_chars[7] = CH_CR;
        load_cnt      = 4'd8;
      end
      MODE_MIN: begin
        load_chars[0] = mm_d[15:8];
        load_chars[1] = mm_d[7:0];
        load_chars[2] = CH_DOT;
        load_chars[3] = sub_d[15:8];
        load_chars[4] = sub_d[7:0];
        load_chars[5] = CH_SPACE;
        load_chars[6] = CH_SPACE;
        load_chars[7] = CH_CR;
        load_cnt      = 4'd8;
      end
      MODE_RAW: begin
        load_chars[0] = hs_d[15:8];
        load_chars[1] = hs_d[7:0];
        load_chars[2] = ls_d[15:8];
        load_chars[3] = ls_d[7:0];
        load_chars[4] = cs_d[15:8];
        load_chars[5] = cs_d[7:0];
        load_chars[6] = CH_CR;
        load_cnt      = 4'd7;
      end
      default: begin
        load_chars = '0;
        load_cnt   = 4'd0;
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r  <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      s5_v_r    <= 1'b0;
      s6_v_r    <= 1'b0;
      chr_cnt_r <= 4'd0;
      out_v_r   <= 1'b0;
    end else begin
      halted_r <= halted_nxt;
      if (rdy1) begin
        s1_v_r <= in_fire && keep;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy4) begin
        s4_v_r <= s3_v_r;
      end
      if (rdy5) begin
        s5_v_r <= s4_v_r;
      end
      if (rdy6) begin
        s6_v_r <= s5_v_r;
      end
      if (load) begin
        chr_cnt_r <= load_cnt;
      end else if (emit) begin
        chr_cnt_r <= chr_cnt_r - 4'd1;
      end
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_mode_r  <= in_mode;
      s1_count_r <= in_data.uptime_count;
    end
    if (rdy2) begin
      s2_mode_r <= s1_mode_r;
      s2_q_r    <= p1[50:39];
      s2_c6_r   <= s1_count_r[30:6];
      s2_low_r  <= s1_count_r[5:0];
    end
    if (rdy3) begin
      s3_mode_r <= s2_mode_r;
      s3_red_r  <= {rem[13:0], s2_low_r};
    end
    if (rdy4) begin
      s4_mode_r <= s3_mode_r;
      s4_red_r  <= s3_red_r;
      s4_secs_r <= p3[40:27];
    end
    if (rdy5) begin
      s5_mode_r <= s4_mode_r;
      s5_cs_r   <= cs_full[6:0];
      s5_secs_r <= s4_secs_r;
      s5_mins_r <= p_min[26:19];
      s5_hs_r   <= p_hs[26:20];
    end
    if (rdy6) begin
      s6_mode_r <= s5_mode_r;
      s6_hs_r   <= s5_hs_r;
      s6_ls_r   <= ls_full[6:0];
      s6_cs_r   <= s5_cs_r;
      s6_mm_r   <= mm;
      s6_sub_r  <= sub_full[5:0];
    end
    if (load) begin
      chr_r <= load_chars;
    end else if (emit) begin
      chr_r <= {8'h00, chr_r[7:1]};
    end
    if (emit) begin
      out_data_r.char_out  <= chr_r[0];
      out_data_r.last_char <= (chr_cnt_r == 4'd1);
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: src/uaf_checker.sv
// Port-level checker for the uptime formatter, bound to the top level.
`default_nettype none

module uaf_checker
  import uaf_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input in_item_t  in_data,
  input wire       out_valid,
  input wire       out_ready,
  input out_item_t out_data
);

  logic       out_fire;
  logic [2:0] run_r;

  assign out_fire = out_valid && out_ready;

  // characters transferred so far in the current run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 3'd0;
    end else if (out_fire) begin
      run_r <= out_data.last_char ? 3'd0 : 3'(run_r + 3'd1);
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  a_cr_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_char == (out_data.char_out == CH_CR)))
    else $error("carriage return and last flag disagree");

  a_run_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_data.last_char |-> run_r != 3'd7)
    else $error("run longer than eight characters");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_data.last_char |-> (run_r == 3'd6) || (run_r == 3'd7))
    else $error("run not seven or eight characters");

  // input side is observed but not constrained here
  logic unused_in;
  assign unused_in = in_valid ^ in_ready ^ (^in_data);

endmodule

bind uptime_ascii_formatter uaf_checker u_uaf_checker (.*);

`default_nettype wire

FILE: tb/tb_uptime_ascii_formatter.sv
// Testbench for uptime_ascii_formatter: random and directed commands checked against a predictor.
`timescale 1ns / 100ps

module tb_uptime_ascii_formatter;
  import uaf_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 500;
  localparam int TAIL_CYCLES  = 24;
  localparam int RANDOM_ITEMS = 430;

  // Predicts the character runs and holds them until the block sends them.
  class char_scoreboard;
    out_item_t expected_chars[$];
    bit        halted;
    int        errors;

    function logic [7:0] digit(int unsigned value, int unsigned divisor);
      return CH_ZERO + 8'((value / divisor) % 10);
    endfunction

    function void note_command(in_item_t item);
      int unsigned count;
      int unsigned secs;
      int unsigned mins;
      int unsigned subs;
      int unsigned divisor;
      logic [7:0]  run[$];
      out_item_t   ch;
      if (halted) return;
      count   = item.uptime_count % 1000000;
      divisor = 100000;
      case (item.command_byte)
        CMD_SECONDS: begin
          repeat (4) begin
            run.push_back(digit(count, divisor));
            divisor /= 10;
          end
          run.push_back(CH_DOT);
          repeat (2) begin
            run.push_back(digit(count, divisor));
            divisor /= 10;
          end
          run.push_back(CH_CR);
        end
        CMD_MINUTES: begin
          secs = count / 100;
          mins = secs / 60;
          subs = secs % 60;
          // minutes past 99 wrap to their last two digits
          run.push_back(digit(mins, 10));
          run.push_back(digit(mins, 1));
          run.push_back(CH_DOT);
          run.push_back(digit(subs, 10));
          run.push_back(digit(subs, 1));
          run.push_back(CH_SPACE);
          run.push_back(CH_SPACE);
          run.push_back(CH_CR);
        end
        CMD_RAW: begin
          repeat (6) begin
            run.push_back(digit(count, divisor));
            divisor /= 10;
          end
          run.push_back(CH_CR);
        end
        CMD_QUIT: halted = 1'b1;
        default: ;
      endcase
      foreach (run[i]) begin
        ch.char_out  = run[i];
        ch.last_char = (i == run.size() - 1);
        expected_chars.push_back(ch);
      end
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_char(out_item_t got);
      out_item_t want;
      if (expected_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected char %h last %b", got.char_out, got.last_char));
        return;
      end
      want = expected_chars.pop_front();
      if (got.char_out !== want.char_out)
        flag_mismatch($sformatf("char_out %h, wanted %h", got.char_out, want.char_out));
      if (got.last_char !== want.last_char)
        flag_mismatch($sformatf("last_char %b on char %h, wanted %b",
                                got.last_char, want.char_out, want.last_char));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  char_scoreboard sb = new();
  bit             hold_off_req = 1'b0;
  int             cycle_count = 0;

  uptime_ascii_formatter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_char(out_data);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("uptime_ascii_formatter test failed");
    $finish;
  end

  // Receiver: random ready pattern, plus one long hold-off on request.
  initial begin
    int r;
    int dur;
    logic rdy;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          rdy = 1'b1;
          dur = $urandom_range(1, 5);
        end else if (r < 55) begin
          rdy = 1'b1;
          dur = $urandom_range(50, 150);
        end else if (r < 92) begin
          rdy = 1'b0;
          dur = $urandom_range(1, 3);
        end else begin
          rdy = 1'b0;
          dur = $urandom_range(10, 40);
        end
        out_ready <= rdy;
        repeat (dur) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] cmd, input logic [30:0] count);
    in_item_t item;
    item.command_byte = cmd;
    item.uptime_count = count;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_command(item);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles == 0) return;
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_chars.size() != 0);
  endtask

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_command();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 27) return CMD_SECONDS;
    if (r < 54) return CMD_MINUTES;
    if (r < 80) return CMD_RAW;
    // any other byte, but never the halt before the closing phase
    do c = 8'($urandom_range(0, 255)); while (c == CMD_QUIT);
    return c;
  endfunction

  function automatic logic [30:0] pick_uptime();
    int r;
    longint base;
    r = $urandom_range(0, 99);
    if (r < 30) return 31'($urandom());
    if (r < 60) return 31'($urandom_range(0, 999999));
    if (r < 75) begin
      base = longint'($urandom_range(1, 2147)) * 1000000;
      return 31'(base - 50 + $urandom_range(0, 99));
    end
    if (r < 90) begin
      // straddle a minute boundary
      base = longint'($urandom_range(0, 170)) * 6000;
      return 31'(base + 5950 + $urandom_range(0, 99));
    end
    return 31'($urandom_range(0, 127));
  endfunction

  initial begin
    bit burst;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, wrap, minute wrap past 99, ignored bytes
    send_item(CMD_SECONDS, 31'd0);
    send_item(CMD_SECONDS, 31'd999999);
    send_item(CMD_SECONDS, 31'd1000000);
    send_item(CMD_SECONDS, 31'h7FFF_FFFF);
    idle_sender(sender_gap());
    send_item(CMD_MINUTES, 31'd0);
    send_item(CMD_MINUTES, 31'd999999);
    send_item(CMD_MINUTES, 31'd359999);
    send_item(CMD_MINUTES, 31'd600000);
    send_item(CMD_MINUTES, 31'd5999);
    send_item(CMD_MINUTES, 31'd6000);
    send_item(CMD_MINUTES, 31'h7FFF_FFFF);
    idle_sender(sender_gap());
    send_item(CMD_RAW, 31'd0);
    send_item(CMD_RAW, 31'd999999);
    send_item(CMD_RAW, 31'd1000000);
    send_item(CMD_RAW, 31'h7FFF_FFFF);
    send_item(CMD_RAW, 31'd1);
    send_item(8'h00, 31'h7FFF_FFFF);
    send_item(8'hFF, 31'd0);
    send_item(8'h30, 31'd123456);
    send_item(8'h34, 31'd123456);
    send_item(8'h51, 31'd42);
    send_item(8'h72, 31'd42);
    send_item(CMD_SECONDS, 31'd123456);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 120) hold_off_req = 1'b1;
      if (i == 280) wait_for_drain();
      burst = (i % 100) < 15;
      send_item(pick_command(), pick_uptime());
      if (!burst) idle_sender(sender_gap());
    end

    // halt: every later command is dropped until reset
    send_item(CMD_QUIT, pick_uptime());
    send_item(CMD_SECONDS, 31'd123456);
    send_item(CMD_MINUTES, 31'h7FFF_FFFF);
    idle_sender(sender_gap());
    send_item(CMD_RAW, 31'd0);
    send_item(CMD_QUIT, 31'd0);
    send_item(8'hFF, pick_uptime());
    send_item(CMD_RAW, pick_uptime());

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_chars.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("uptime_ascii_formatter test passed");
    else
      $display("uptime_ascii_formatter test failed");
    $finish;
  end

endmodule

FILE: sim.f
src/uaf_pkg.sv
src/uptime_ascii_formatter.sv
src/uaf_checker.sv
tb/tb_uptime_ascii_formatter.sv
